// File: design/mpc_pkg.sv
// shared types, codes and constants of the moisture pump controller
`timescale 1ns / 1ps
package mpc_pkg;

  localparam logic [31:0] MAX_FORWARD_MS = 32'h7FFF_FFFF;
  localparam logic [9:0]  PERMILLE_FULL  = 10'd1000;

  // reset values of the configuration registers
  localparam logic [9:0]  START_BELOW_RESET = 10'd300;
  localparam logic [9:0]  STOP_AT_RESET     = 10'd600;
  localparam logic [31:0] MAX_ON_RESET      = 32'd60000;
  localparam logic [31:0] MIN_OFF_RESET     = 32'd300000;

  typedef enum logic [1:0] {
    CMD_STEP     = 2'd0,
    CMD_INIT     = 2'd1,
    CMD_SHUTDOWN = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_START_BELOW = 2'd0,
    REG_STOP_AT     = 2'd1,
    REG_MAX_ON      = 2'd2,
    REG_MIN_OFF     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOINIT = 2'd1,
    ST_HWFAIL = 2'd2,
    ST_BADCFG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_WATER    = 3'd2,
    MODE_LOCK     = 3'd3,
    MODE_SENSOR   = 3'd4,
    MODE_OUTFAULT = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    WHY_NONE      = 4'd0,
    WHY_BADSAMPLE = 4'd1,
    WHY_INHIBIT   = 4'd2,
    WHY_MAXON     = 4'd3,
    WHY_WET       = 4'd4,
    WHY_MINOFF    = 4'd5,
    WHY_DRY       = 4'd6,
    WHY_OUTFAIL   = 4'd7,
    WHY_SHUTDOWN  = 4'd8
  } why_t;

  typedef struct packed {
    logic [9:0]  start_below_permille;
    logic [9:0]  stop_at_permille;
    logic [31:0] max_on_ms;
    logic [31:0] min_off_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic        sample_valid;
    logic [9:0]  moisture_permille;
    logic        watering_allowed;
    logic        pump_fault;
  } item_t;

  typedef struct packed {
    logic        ready;
    logic        has_mode_time;
    mode_t       mode;
    why_t        why;
    logic        requested_level;
    logic        applied_level;
    logic [31:0] since_time;
  } ctl_state_t;

endpackage

// File: design/mpc_intf.sv
// valid/ready channels for input words and result words
`timescale 1ns / 1ps
interface mpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_ms;
  logic        sample_valid;
  logic [9:0]  moisture_permille;
  logic        watering_allowed;
  logic        pump_fault;

  modport source (
    output valid, command, now_ms, sample_valid, moisture_permille,
           watering_allowed, pump_fault,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, sample_valid, moisture_permille,
           watering_allowed, pump_fault,
    output ready
  );
endinterface

interface mpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  mode;
  logic [3:0]  why;
  logic        pump_request;
  logic        pump_drive;
  logic [31:0] mode_since_ms;

  modport source (
    output valid, status, mode, why, pump_request, pump_drive, mode_since_ms,
    input  ready
  );
  modport sink (
    input  valid, status, mode, why, pump_request, pump_drive, mode_since_ms,
    output ready
  );
endinterface

// File: design/mpc_core.sv
// next-state logic of the controller: decision, pump drive, init and shutdown
`timescale 1ns / 1ps
module mpc_core (
  input  mpc_pkg::cfg_t       cfg,
  input  mpc_pkg::ctl_state_t cur,
  input  mpc_pkg::item_t      item,
  output mpc_pkg::ctl_state_t state_next,
  output mpc_pkg::status_t    status
);
  import mpc_pkg::*;

  logic [31:0] elapsed;
  logic        on_elapsed;
  logic        off_elapsed;
  logic        sample_ok;
  logic        cfg_ok;
  logic        go;
  mode_t       go_mode;
  why_t        go_why;
  logic        go_level;
  ctl_state_t  dec;

  // wraparound time since the mode time was last restarted
  assign elapsed     = item.now_ms - cur.since_time;
  assign on_elapsed  = elapsed >= cfg.max_on_ms;
  assign off_elapsed = elapsed >= cfg.min_off_ms;
  assign sample_ok   = item.sample_valid && (item.moisture_permille <= PERMILLE_FULL);

  assign cfg_ok = (cfg.start_below_permille < cfg.stop_at_permille) &&
                  (cfg.stop_at_permille <= PERMILLE_FULL) &&
                  (cfg.max_on_ms != 32'd0) && (cfg.min_off_ms != 32'd0) &&
                  (cfg.max_on_ms <= MAX_FORWARD_MS) &&
                  (cfg.min_off_ms <= MAX_FORWARD_MS);

  // hysteresis decision: picks a mode change or a tweak of the reason
  always_comb begin
    go       = 1'b0;
    go_mode  = MODE_IDLE;
    go_why   = WHY_NONE;
    go_level = 1'b0;
    dec      = cur;
    if (!sample_ok) begin
      go      = 1'b1;
      go_mode = MODE_SENSOR;
      go_why  = WHY_BADSAMPLE;
    end else if (!item.watering_allowed) begin
      go     = 1'b1;
      go_why = WHY_INHIBIT;
    end else if (!cur.has_mode_time || cur.mode == MODE_SENSOR) begin
      go = 1'b1;
    end else if (cur.mode == MODE_WATER) begin
      if (on_elapsed) begin
        go      = 1'b1;
        go_mode = MODE_LOCK;
        go_why  = WHY_MAXON;
      end else if (item.moisture_permille >= cfg.stop_at_permille) begin
        go     = 1'b1;
        go_why = WHY_WET;
      end
    end else if (cur.mode == MODE_LOCK) begin
      // lockout ends without restarting the mode time
      if (off_elapsed) begin
        dec.mode            = MODE_IDLE;
        dec.why             = WHY_MINOFF;
        dec.requested_level = 1'b0;
      end
    end else if (item.moisture_permille < cfg.start_below_permille) begin
      if (off_elapsed) begin
        go       = 1'b1;
        go_mode  = MODE_WATER;
        go_why   = WHY_DRY;
        go_level = 1'b1;
      end else begin
        dec.why = WHY_MINOFF;
      end
    end
    if (go) begin
      if (cur.mode != go_mode) begin
        dec.since_time = item.now_ms;
      end
      dec.mode            = go_mode;
      dec.why             = go_why;
      dec.requested_level = go_level;
      dec.has_mode_time   = 1'b1;
    end
  end

  // command decode, then drive the pump when the request changed
  always_comb begin
    state_next = cur;
    status     = ST_OK;
    unique case (cmd_t'(item.command))
      CMD_STEP: begin
        if (!cur.ready) begin
          status = ST_NOINIT;
        end else if (cur.mode == MODE_OUTFAULT) begin
          state_next.requested_level = 1'b0;
          status                     = ST_HWFAIL;
        end else begin
          state_next = dec;
          if (dec.requested_level != dec.applied_level) begin
            if (item.pump_fault) begin
              state_next.mode            = MODE_OUTFAULT;
              state_next.why             = WHY_OUTFAIL;
              state_next.requested_level = 1'b0;
              state_next.applied_level   = 1'b0;
              status                     = ST_HWFAIL;
            end else begin
              state_next.applied_level = dec.requested_level;
            end
          end
        end
      end
      CMD_INIT: begin
        if (cur.ready) begin
          status = (cur.mode == MODE_OUTFAULT) ? ST_HWFAIL : ST_OK;
        end else if (!cfg_ok) begin
          status = ST_BADCFG;
        end else if (item.pump_fault) begin
          status = ST_HWFAIL;
        end else begin
          state_next.mode            = MODE_START;
          state_next.why             = WHY_NONE;
          state_next.requested_level = 1'b0;
          state_next.applied_level   = 1'b0;
          state_next.since_time      = 32'd0;
          state_next.has_mode_time   = 1'b0;
          state_next.ready           = 1'b1;
        end
      end
      CMD_SHUTDOWN: begin
        if (cur.ready) begin
          state_next.mode            = MODE_START;
          state_next.why             = WHY_SHUTDOWN;
          state_next.requested_level = 1'b0;
          state_next.applied_level   = 1'b0;
          state_next.since_time      = 32'd0;
          state_next.has_mode_time   = 1'b0;
          state_next.ready           = 1'b0;
        end
      end
      default: begin
        // unused command code leaves everything as it is
        state_next = cur;
      end
    endcase
  end

endmodule

// File: design/moisture_pump_controller_top.sv
// top level: input register, controller state, result register and config port
// an input word is held in the input register; its result is held in the result register
// throughput: one word per cycle unless stalled; the controller state updates once per word
// a stalled result word holds both stages; an empty input stage still takes one word
// reset (rst, synchronous): controller not initialized, mode starting, pump off,
// configuration back to its defaults, both stages empty
`timescale 1ns / 1ps
module moisture_pump_controller_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  mpc_pkg::cfg_idx_t   cfg_index,
  input  logic [31:0]         cfg_data,
  mpc_in_if.sink              in_ch,
  mpc_out_if.source           out_ch
);
  import mpc_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  item_t      item;
  ctl_state_t state;
  ctl_state_t state_next;
  status_t    status_next;
  logic       out_valid;
  status_t    out_status;
  logic       advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_below_permille <= START_BELOW_RESET;
      cfg.stop_at_permille     <= STOP_AT_RESET;
      cfg.max_on_ms            <= MAX_ON_RESET;
      cfg.min_off_ms           <= MIN_OFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BELOW: cfg.start_below_permille <= cfg_data[9:0];
        REG_STOP_AT:     cfg.stop_at_permille     <= cfg_data[9:0];
        REG_MAX_ON:      cfg.max_on_ms            <= cfg_data;
        REG_MIN_OFF:     cfg.min_off_ms           <= cfg_data;
        default:         cfg.min_off_ms           <= cfg.min_off_ms;
      endcase
    end
  end

  // pipeline moves whenever the result register is free or being taken
  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item.command           <= in_ch.command;
      item.now_ms            <= in_ch.now_ms;
      item.sample_valid      <= in_ch.sample_valid;
      item.moisture_permille <= in_ch.moisture_permille;
      item.watering_allowed  <= in_ch.watering_allowed;
      item.pump_fault        <= in_ch.pump_fault;
    end
  end

  mpc_core u_core (
    .cfg        (cfg),
    .cur        (state),
    .item       (item),
    .state_next (state_next),
    .status     (status_next)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.ready           <= 1'b0;
      state.has_mode_time   <= 1'b0;
      state.mode            <= MODE_START;
      state.why             <= WHY_NONE;
      state.requested_level <= 1'b0;
      state.applied_level   <= 1'b0;
      state.since_time      <= 32'd0;
    end else if (advance && in_valid) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_status <= status_next;
    end
  end

  // result word shows the state after its input word
  assign out_ch.valid         = out_valid;
  assign out_ch.status        = out_status;
  assign out_ch.mode          = state.mode;
  assign out_ch.why           = state.why;
  assign out_ch.pump_request  = state.requested_level;
  assign out_ch.pump_drive    = state.applied_level;
  assign out_ch.mode_since_ms = state.since_time;

endmodule

// File: design/mpc_checker.sv
// port-level checks of the controller result channel, bound to the top level
`timescale 1ns / 1ps
module mpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [2:0]  mode,
  input logic        pump_request,
  input logic        pump_drive,
  input logic [31:0] mode_since_ms
);
  import mpc_pkg::*;

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(status) &&
      $stable(pump_drive) && $stable(mode_since_ms))
    else $error("result word changed while stalled");

  // the pump only runs while watering and asked for
  a_drive_water: assert property (@(posedge clk) disable iff (rst)
    out_valid && pump_drive |-> mode == MODE_WATER && pump_request)
    else $error("pump driven outside watering");

  // output fault keeps the request off
  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_OUTFAULT |-> !pump_request && !pump_drive)
    else $error("pump request in output fault");

  // an uninitialized controller sits in starting with the pump off
  a_noinit_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOINIT |-> mode == MODE_START && !pump_drive)
    else $error("not initialized but not in starting");

endmodule

bind moisture_pump_controller_top mpc_checker u_mpc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .mode          (out_ch.mode),
  .pump_request  (out_ch.pump_request),
  .pump_drive    (out_ch.pump_drive),
  .mode_since_ms (out_ch.mode_since_ms)
);
